// ----- rtl/core/sstf_pkg.sv -----
// ----------------------------------------------------------------------------
// sstf_pkg
// Shared constants and types for the shortest-seek-time-first scheduler.
// ----------------------------------------------------------------------------
package sstf_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int CYL_BITS     = 16;
    localparam int SUM_BITS     = 21;
    localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);

    localparam logic [SUM_BITS-1:0] SUM_MAX  = {SUM_BITS{1'b1}};
    localparam logic [CYL_BITS-1:0] DISK_RST = {CYL_BITS{1'b1}};

    typedef logic [CYL_BITS-1:0] cyl_t;
    typedef logic [CYL_BITS:0]   cylx_t;
    typedef logic [SUM_BITS-1:0] sum_t;
    typedef logic [SUM_BITS:0]   sumx_t;
    typedef logic [IDX_BITS-1:0] idx_t;
    typedef logic [CNT_BITS-1:0] cnt_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SELECT,
        ST_WAIT
    } state_t;

endpackage

// ----- rtl/core/sstf_ram.sv -----
// ----------------------------------------------------------------------------
// sstf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sstf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/sstf_seek_scheduler.sv -----
// ----------------------------------------------------------------------------
// sstf_seek_scheduler
// Queues cylinder requests and serves them nearest-first from a head position.
// ----------------------------------------------------------------------------
// Load request: produces no result.
// Start request: head result in the cycle after acceptance; each further result
//   follows acceptance of the previous one after a scan of the table (one
//   table entry per cycle through the single RAM read port and one distance
//   compare unit), plus output stalls. No request is taken during a run.
// Reset: asynchronous; count, served flags and the dropped flag clear at once, no
//   clearing pass; the overflow output is not reset; disk_size returns to 65535.
module sstf_seek_scheduler (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sstf_pkg::CYL_BITS-1:0] cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          func,
    input  logic [sstf_pkg::CYL_BITS-1:0] cylinder,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [sstf_pkg::CYL_BITS-1:0] position,
    output logic [sstf_pkg::SUM_BITS-1:0] total_distance,
    output logic                          last,
    output logic                          overflow
);

    sstf_pkg::state_t                  state_reg, state_next;
    sstf_pkg::cyl_t                    disk_size_reg, disk_size_next;
    sstf_pkg::cnt_t                    count_reg, count_next;
    sstf_pkg::cnt_t                    left_reg, left_next;
    sstf_pkg::cnt_t                    idx_reg, idx_next;
    logic [sstf_pkg::MAX_REQUESTS-1:0] served_reg, served_next;
    logic                              dropped_reg, dropped_next;
    logic                              found_reg, found_next;
    logic                              chk_valid_reg, chk_valid_next;
    sstf_pkg::idx_t                    chk_idx_reg, chk_idx_next;
    logic                              out_valid_reg, out_valid_next;

    sstf_pkg::cyl_t                    head_reg, head_next;
    sstf_pkg::sum_t                    sum_reg, sum_next;
    sstf_pkg::idx_t                    best_reg, best_next;
    sstf_pkg::cyl_t                    bestd_reg, bestd_next;
    sstf_pkg::cyl_t                    bestpos_reg, bestpos_next;
    sstf_pkg::cyl_t                    pos_reg, pos_next;
    sstf_pkg::sum_t                    tot_reg, tot_next;
    logic                              last_reg, last_next;
    logic                              ovf_reg, ovf_next;

    logic                              ram_we;
    sstf_pkg::idx_t                    ram_raddr;
    sstf_pkg::cyl_t                    ram_rdata;
    sstf_pkg::cyl_t                    seek_gap;
    sstf_pkg::sumx_t                   sum_add;
    logic                              in_acc;
    logic                              in_range;

    sstf_ram #(
        .WIDTH (sstf_pkg::CYL_BITS),
        .DEPTH (sstf_pkg::MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[sstf_pkg::IDX_BITS-1:0]),
        .wdata (cylinder),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_stall = (state_reg != sstf_pkg::ST_IDLE) || (out_valid_reg && func);
    assign in_acc   = in_valid && !in_stall;
    assign in_range = (sstf_pkg::cylx_t'(cylinder) + sstf_pkg::cylx_t'(1))
                      < sstf_pkg::cylx_t'(disk_size_reg);
    assign seek_gap = (head_reg >= ram_rdata) ? (head_reg - ram_rdata)
                                              : (ram_rdata - head_reg);
    assign sum_add  = sstf_pkg::sumx_t'(sum_reg) + sstf_pkg::sumx_t'(bestd_reg);

    assign out_valid      = out_valid_reg;
    assign position       = pos_reg;
    assign total_distance = tot_reg;
    assign last           = last_reg;
    assign overflow       = ovf_reg;

    always_comb
    begin
        state_next     = state_reg;
        disk_size_next = cfg_wr_en ? cfg_wr_data : disk_size_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        idx_next       = idx_reg;
        served_next    = served_reg;
        dropped_next   = dropped_reg;
        found_next     = found_reg;
        chk_valid_next = 1'b0;
        chk_idx_next   = chk_idx_reg;
        out_valid_next = out_valid_reg && out_stall;
        head_next      = head_reg;
        sum_next       = sum_reg;
        best_next      = best_reg;
        bestd_next     = bestd_reg;
        bestpos_next   = bestpos_reg;
        pos_next       = pos_reg;
        tot_next       = tot_reg;
        last_next      = last_reg;
        ovf_next       = ovf_reg;
        ram_we         = 1'b0;
        ram_raddr      = idx_reg[sstf_pkg::IDX_BITS-1:0];

        // compare stage for the entry read last cycle
        if (chk_valid_reg && !served_reg[chk_idx_reg] && (!found_reg || seek_gap < bestd_reg))
        begin
            found_next   = 1'b1;
            best_next    = chk_idx_reg;
            bestd_next   = seek_gap;
            bestpos_next = ram_rdata;
        end

        case (state_reg)
            sstf_pkg::ST_IDLE:
            begin
                if (in_acc && !func && in_range)
                begin
                    if (count_reg < sstf_pkg::cnt_t'(sstf_pkg::MAX_REQUESTS))
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + sstf_pkg::cnt_t'(1);
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                end
                else if (in_acc && func)
                begin
                    head_next      = cylinder;
                    sum_next       = '0;
                    left_next      = count_reg;
                    out_valid_next = 1'b1;
                    pos_next       = cylinder;
                    tot_next       = '0;
                    last_next      = (count_reg == '0);
                    ovf_next       = dropped_reg;
                    if (count_reg == '0)
                    begin
                        dropped_next = 1'b0;
                    end
                    else
                    begin
                        state_next = sstf_pkg::ST_WAIT;
                    end
                end
            end
            sstf_pkg::ST_WAIT:
            begin
                if (!out_valid_reg)
                begin
                    idx_next   = '0;
                    found_next = 1'b0;
                    state_next = sstf_pkg::ST_SCAN;
                end
            end
            sstf_pkg::ST_SCAN:
            begin
                if (idx_reg < count_reg)
                begin
                    chk_valid_next = 1'b1;
                    chk_idx_next   = idx_reg[sstf_pkg::IDX_BITS-1:0];
                    idx_next       = idx_reg + sstf_pkg::cnt_t'(1);
                end
                else if (!chk_valid_reg)
                begin
                    state_next = sstf_pkg::ST_SELECT;
                end
            end
            sstf_pkg::ST_SELECT:
            begin
                served_next[best_reg] = 1'b1;
                sum_next       = sum_add[sstf_pkg::SUM_BITS] ? sstf_pkg::SUM_MAX
                                                             : sum_add[sstf_pkg::SUM_BITS-1:0];
                head_next      = bestpos_reg;
                left_next      = left_reg - sstf_pkg::cnt_t'(1);
                out_valid_next = 1'b1;
                pos_next       = bestpos_reg;
                tot_next       = sum_add[sstf_pkg::SUM_BITS] ? sstf_pkg::SUM_MAX
                                                             : sum_add[sstf_pkg::SUM_BITS-1:0];
                last_next      = (left_reg == sstf_pkg::cnt_t'(1));
                ovf_next       = dropped_reg;
                if (left_reg == sstf_pkg::cnt_t'(1))
                begin
                    count_next   = '0;
                    served_next  = '0;
                    dropped_next = 1'b0;
                    state_next   = sstf_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = sstf_pkg::ST_WAIT;
                end
            end
            default:
            begin
                state_next = sstf_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sstf_pkg::ST_IDLE;
            disk_size_reg <= sstf_pkg::DISK_RST;
            count_reg     <= '0;
            left_reg      <= '0;
            idx_reg       <= '0;
            served_reg    <= '0;
            dropped_reg   <= 1'b0;
            found_reg     <= 1'b0;
            chk_valid_reg <= 1'b0;
            chk_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            disk_size_reg <= disk_size_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
            idx_reg       <= idx_next;
            served_reg    <= served_next;
            dropped_reg   <= dropped_next;
            found_reg     <= found_next;
            chk_valid_reg <= chk_valid_next;
            chk_idx_reg   <= chk_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg    <= head_next;
        sum_reg     <= sum_next;
        best_reg    <= best_next;
        bestd_reg   <= bestd_next;
        bestpos_reg <= bestpos_next;
        pos_reg     <= pos_next;
        tot_reg     <= tot_next;
        last_reg    <= last_next;
        ovf_reg     <= ovf_next;
    end

endmodule

// ----- rtl/core/sstf_checker.sv -----
// ----------------------------------------------------------------------------
// sstf_checker
// Port-level checks for the seek scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module sstf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          func,
    input logic [sstf_pkg::CYL_BITS-1:0] cylinder,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [sstf_pkg::SUM_BITS-1:0] total_distance,
    input logic [sstf_pkg::CYL_BITS-1:0] position,
    input logic                          last
);

    // start request: head result with zero distance on the next cycle
    a_start_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && func |=>
            out_valid && position == $past(cylinder) && total_distance == '0)
        else $error("start request did not produce head result");

    // load request never produces a result
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !func && !out_valid |=> !out_valid)
        else $error("load request produced a result");

    // run still in progress after a non-final result
    a_busy_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> in_stall)
        else $error("request accepted in the middle of a run");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(position))
        else $error("stalled result dropped or changed");

endmodule

bind sstf_seek_scheduler sstf_checker u_sstf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .func           (func),
    .cylinder       (cylinder),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .total_distance (total_distance),
    .position       (position),
    .last           (last)
);

// ----- tb/sstf_checker.sv -----
// ----------------------------------------------------------------------------
// sstf_tb_checker
// Tracks the seek scheduler's request table, predicts every result of a
// start request and compares each accepted result against the oldest one
// still pending. Reports the mismatch count and the number of outstanding
// results back to the testbench top.
// ----------------------------------------------------------------------------
module sstf_tb_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [sstf_pkg::CYL_BITS-1:0] cfg_wr_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          func,
    input  logic [sstf_pkg::CYL_BITS-1:0] cylinder,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [sstf_pkg::CYL_BITS-1:0] position,
    input  logic [sstf_pkg::SUM_BITS-1:0] total_distance,
    input  logic                          last,
    input  logic                          overflow,
    output int                            mismatches,
    output int                            pending
);

    typedef struct packed {
        sstf_pkg::cyl_t position;
        sstf_pkg::sum_t total;
        logic           last;
        logic           overflow;
    } seek_result_t;

    sstf_pkg::cyl_t disk_size;
    sstf_pkg::cyl_t req_table [sstf_pkg::MAX_REQUESTS];
    int             req_count;
    logic           dropped;
    seek_result_t   schedule_q [$];

    function automatic void queue_request(sstf_pkg::cyl_t cyl);
        int cyl_val;
        int size_val;
        cyl_val  = cyl;
        size_val = disk_size;
        if (cyl_val + 1 < size_val)
        begin
            if (req_count < sstf_pkg::MAX_REQUESTS)
            begin
                req_table[req_count] = cyl;
                req_count++;
            end
            else
                dropped = 1'b1;
        end
    endfunction

    function automatic void serve_schedule(sstf_pkg::cyl_t start_head);
        logic         done [sstf_pkg::MAX_REQUESTS];
        int           head;
        int           sum;
        int           best;
        int           best_gap;
        int           d;
        int           req_val;
        seek_result_t r;
        done = '{default: 1'b0};
        head = start_head;
        sum  = 0;
        r    = '{sstf_pkg::cyl_t'(head), sstf_pkg::sum_t'(0), (req_count == 0), dropped};
        schedule_q.push_back(r);
        for (int left = req_count; left > 0; left--)
        begin
            best     = -1;
            best_gap = 0;
            for (int i = 0; i < req_count; i++)
            begin
                if (!done[i])
                begin
                    req_val = req_table[i];
                    d = (head > req_val) ? head - req_val : req_val - head;
                    if (best < 0 || d < best_gap)
                    begin
                        best     = i;
                        best_gap = d;
                    end
                end
            end
            done[best] = 1'b1;
            sum = sum + best_gap;
            if (sum > int'(sstf_pkg::SUM_MAX))
                sum = int'(sstf_pkg::SUM_MAX);
            head = req_table[best];
            r = '{sstf_pkg::cyl_t'(head), sstf_pkg::sum_t'(sum), (left == 1), dropped};
            schedule_q.push_back(r);
        end
        req_count = 0;
        dropped   = 1'b0;
    endfunction

    function automatic void note_mismatch(string what, seek_result_t exp_r,
                                          seek_result_t got_r);
        mismatches++;
        if (mismatches <= 10)
            $display({"ERROR %s: exp pos=%0d dist=%0d last=%0b ovf=%0b, ",
                      "got pos=%0d dist=%0d last=%0b ovf=%0b"},
                     what, exp_r.position, exp_r.total, exp_r.last, exp_r.overflow,
                     got_r.position, got_r.total, got_r.last, got_r.overflow);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        seek_result_t got_r;
        seek_result_t exp_r;
        if (!rst_n)
        begin
            disk_size  = sstf_pkg::DISK_RST;
            req_count  = 0;
            dropped    = 1'b0;
            schedule_q.delete();
            pending    = 0;
            mismatches = 0;
        end
        else
        begin
            if (cfg_wr_en)
                disk_size = cfg_wr_data;
            if (in_valid && !in_stall)
            begin
                if (func)
                    serve_schedule(cylinder);
                else
                    queue_request(cylinder);
            end
            if (out_valid && !out_stall)
            begin
                got_r = '{position, total_distance, last, overflow};
                if (schedule_q.size() == 0)
                    note_mismatch("unexpected result", '0, got_r);
                else
                begin
                    exp_r = schedule_q.pop_front();
                    if (got_r.position !== exp_r.position || got_r.total !== exp_r.total ||
                        got_r.last !== exp_r.last || got_r.overflow !== exp_r.overflow)
                        note_mismatch("result", exp_r, got_r);
                end
            end
            pending = schedule_q.size();
        end
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for sstf_seek_scheduler. Runs a short directed sequence, then
// random batches of load requests each closed by a start request, across
// several disk sizes and sender/receiver idling phases. Checking is done by
// sstf_tb_checker; this module drives stimulus and reports the verdict.
// ----------------------------------------------------------------------------
module tb;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASE_ITEMS = 50;

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           cfg_wr_en = 1'b0;
    sstf_pkg::cyl_t cfg_wr_data = '0;
    logic           in_valid = 1'b0;
    logic           in_stall;
    logic           func = 1'b0;
    sstf_pkg::cyl_t cylinder = '0;
    logic           out_valid;
    logic           out_stall = 1'b0;
    sstf_pkg::cyl_t position;
    sstf_pkg::sum_t total_distance;
    logic           last;
    logic           overflow;

    int             mismatches;
    int             pending;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             sent_items = 0;
    int             quiet_cycles = 0;
    sstf_pkg::cyl_t size_now = sstf_pkg::DISK_RST;
    sstf_pkg::cyl_t last_cyl = '0;

    sstf_seek_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .cylinder       (cylinder),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .total_distance (total_distance),
        .last           (last),
        .overflow       (overflow)
    );

    sstf_tb_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .cylinder       (cylinder),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .position       (position),
        .total_distance (total_distance),
        .last           (last),
        .overflow       (overflow),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    always #6 clk = ~clk;

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one request, with random sender gaps in front of it
    task automatic send_request(logic f, sstf_pkg::cyl_t c);
        while ($urandom_range(0, 99) < send_idle_pct)
            @(negedge clk);
        in_valid = 1'b1;
        func     = f;
        cylinder = c;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid = 1'b0;
        sent_items++;
        last_cyl = c;
    endtask

    task automatic wait_results();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_disk_size(sstf_pkg::cyl_t v);
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        size_now  = v;
    endtask

    function automatic sstf_pkg::cyl_t pick_cylinder();
        int lim;
        lim = (size_now >= 2) ? int'(size_now) - 2 : 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return sstf_pkg::cyl_t'($urandom_range(0, lim));
            5:             return sstf_pkg::cyl_t'($urandom);
            6:             return sstf_pkg::cyl_t'(size_now
                                                   - sstf_pkg::cyl_t'($urandom_range(0, 2)));
            7:             return last_cyl;
            8:             return sstf_pkg::cyl_t'(last_cyl
                                                   + sstf_pkg::cyl_t'($urandom_range(0, 8))
                                                   - sstf_pkg::cyl_t'(4));
            default:       return $urandom_range(0, 1) ? {sstf_pkg::CYL_BITS{1'b1}} : '0;
        endcase
    endfunction

    task automatic run_batches(int target);
        int n_loads;
        int sel;
        int goal;
        goal = sent_items + target;
        while (sent_items < goal)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 8)
            begin
                // noise: random requests of either kind
                repeat ($urandom_range(1, 4))
                    send_request(logic'($urandom_range(0, 1)), sstf_pkg::cyl_t'($urandom));
            end
            else
            begin
                if (sel < 65)
                    n_loads = $urandom_range(0, 12);
                else if (sel < 88)
                    n_loads = $urandom_range(13, sstf_pkg::MAX_REQUESTS);
                else
                    n_loads = $urandom_range(sstf_pkg::MAX_REQUESTS + 1,
                                             sstf_pkg::MAX_REQUESTS + 8);
                repeat (n_loads)
                    send_request(1'b0, pick_cylinder());
                if ($urandom_range(0, 9) == 0)
                    wait_results();
                send_request(1'b1, ($urandom_range(0, 3) == 0) ? sstf_pkg::cyl_t'($urandom)
                                                                : pick_cylinder());
            end
        end
    endtask

    initial
    begin
        sstf_pkg::cyl_t sizes [8];
        sizes = '{16'hFFFF, 16'd2, 16'd5000, 16'hFFFE, 16'd3, 16'd0, 16'd700, 16'hFFFF};
        sizes[5] = sstf_pkg::cyl_t'($urandom_range(1, 65535));

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, range edges, tie on distance, tiny disks
        send_request(1'b1, 16'd1234);
        send_request(1'b0, 16'd0);
        send_request(1'b0, 16'd65533);
        send_request(1'b0, 16'd65534);
        send_request(1'b0, 16'd65535);
        send_request(1'b0, 16'd100);
        send_request(1'b0, 16'd300);
        send_request(1'b0, 16'd100);
        send_request(1'b1, 16'd200);
        wait_results();
        write_disk_size(16'd2);
        send_request(1'b0, 16'd0);
        send_request(1'b0, 16'd1);
        send_request(1'b1, 16'd1);
        write_disk_size(16'd1);
        send_request(1'b0, 16'd0);
        send_request(1'b1, 16'd0);
        write_disk_size(16'd0);
        send_request(1'b0, 16'd0);
        send_request(1'b1, 16'hFFFF);
        write_disk_size(16'hFFFF);
        send_request(1'b0, 16'd65533);
        send_request(1'b1, 16'd0);

        for (int ph = 0; ph < 8; ph++)
        begin
            write_disk_size(sizes[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 83; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 83; end
                default: begin send_idle_pct = 37; stall_pct = 37; end
            endcase
            run_batches(PHASE_ITEMS);
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
